// File: rtl/xbf_pkg.sv
// ----------------------------------------------------------------------------
// xbf_pkg
// Shared types and constants for the XOR block fold checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package xbf_pkg;

    localparam int BYTE_W = 8;
    localparam int OUT_W  = 64;
    localparam int LG_W   = 3;
    localparam int CNT_W  = 3;

    // block width codes (log2 of bits)
    localparam logic [LG_W-1:0] LG_NIBBLE = 3'd2;
    localparam logic [LG_W-1:0] LG_BYTE   = 3'd3;
    localparam logic [LG_W-1:0] LG_MAX    = 3'd6;
    localparam logic [LG_W-1:0] LG_RESET  = 3'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              end_of_stream;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

`default_nettype wire

// File: rtl/xbf_if.sv
// ----------------------------------------------------------------------------
// xbf_in_if / xbf_out_if
// Valid/ready channels for stream bytes in and fold results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface xbf_in_if;
    logic                      valid;
    logic                      ready;
    logic [xbf_pkg::BYTE_W-1:0] data_byte;
    logic                      byte_present;
    logic                      end_of_stream;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_stream, output ready);
endinterface

interface xbf_out_if;
    logic                      valid;
    logic                      ready;
    logic [xbf_pkg::OUT_W-1:0] fold_value;

    modport source (output valid, output fold_value, input ready);
    modport sink   (input valid, input fold_value, output ready);
endinterface

`default_nettype wire

// File: rtl/xbf_in_reg.sv
// ----------------------------------------------------------------------------
// xbf_in_reg
// Input register: captures one item per transfer and holds it until the
// fold unit takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module xbf_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    xbf_in_if.sink               i_in,
    input  wire logic            i_take,
    output xbf_pkg::t_stage      o_stage
);

    logic           r_valid;
    logic           n_valid;
    xbf_pkg::t_item r_item;
    xbf_pkg::t_item n_item;
    logic           accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (accept) begin
            n_valid              = 1'b1;
            n_item.data_byte     = i_in.data_byte;
            n_item.byte_present  = i_in.byte_present;
            n_item.end_of_stream = i_in.end_of_stream;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

// File: rtl/xbf_fold.sv
// ----------------------------------------------------------------------------
// xbf_fold
// Fold unit: packs bytes into blocks (4-bit mode: XORs each byte's nibbles),
// XORs full blocks in the accumulator, loads padded fold into result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xbf_fold #(
    parameter int W = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire logic [xbf_pkg::LG_W-1:0]  i_lg,
    input  xbf_pkg::t_stage                i_stage,
    output logic                           o_take,
    xbf_out_if.source                      o_out
);

    logic [W-1:0]                r_acc;
    logic [W-1:0]                n_acc;
    logic [W-1:0]                r_part;
    logic [W-1:0]                n_part;
    logic [xbf_pkg::CNT_W-1:0]   r_cnt;
    logic [xbf_pkg::CNT_W-1:0]   n_cnt;
    logic                        r_started;
    logic                        n_started;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [W-1:0]                r_fold;
    logic [W-1:0]                n_fold;

    logic [W+xbf_pkg::BYTE_W-1:0] wide;
    logic [W-1:0]                 part_shift;
    logic [xbf_pkg::CNT_W:0]      cnt_inc;
    logic [xbf_pkg::CNT_W:0]      blk_len;
    logic [xbf_pkg::CNT_W:0]      pad;
    logic [W-1:0]                 acc_byte;
    logic [xbf_pkg::BYTE_W-1:0]   b;

    assign b = i_stage.item.data_byte;

    // an end item needs a free result slot
    assign o_take = i_stage.valid &&
                    (!i_stage.item.end_of_stream || !r_out_valid || o_out.ready);

    assign blk_len     = (xbf_pkg::CNT_W+1)'(1) << 2'(i_lg - xbf_pkg::LG_BYTE);
    assign wide        = {r_part, b};
    assign part_shift  = wide[W-1:0];
    assign cnt_inc     = {1'b0, r_cnt} + (xbf_pkg::CNT_W+1)'(1);

    always_comb begin
        n_acc       = r_acc;
        n_part      = r_part;
        n_cnt       = r_cnt;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        n_fold      = r_fold;
        acc_byte    = r_acc;
        pad         = '0;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (o_take) begin
            // fold in the byte
            if (i_stage.item.byte_present) begin
                if (i_lg == xbf_pkg::LG_NIBBLE) begin
                    acc_byte = r_acc ^ W'(b[7:4] ^ b[3:0]);
                end else if (cnt_inc == blk_len) begin
                    acc_byte  = r_acc ^ part_shift;
                    n_part    = '0;
                    n_cnt     = '0;
                    n_started = 1'b0;
                end else begin
                    n_part    = part_shift;
                    n_cnt     = cnt_inc[xbf_pkg::CNT_W-1:0];
                    n_started = 1'b1;
                end
            end
            n_acc = acc_byte;

            // close the stream: pad the open block at its low end
            if (i_stage.item.end_of_stream) begin
                pad = blk_len - {1'b0, n_cnt};
                if (n_started && i_lg != xbf_pkg::LG_NIBBLE) begin
                    n_fold = acc_byte ^ (n_part << {pad[xbf_pkg::CNT_W-1:0], 3'b000});
                end else begin
                    n_fold = acc_byte;
                end
                n_out_valid = 1'b1;
                n_acc       = '0;
                n_part      = '0;
                n_cnt       = '0;
                n_started   = 1'b0;
            end
        end

        if (i_clear) begin
            n_acc     = '0;
            n_part    = '0;
            n_cnt     = '0;
            n_started = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_part      <= '0;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_part      <= n_part;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fold <= n_fold;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.fold_value = xbf_pkg::OUT_W'(r_fold);

endmodule

`default_nettype wire

// File: rtl/xor_block_fold_core.sv
// A result is loaded into the result register when its end item is taken.
// Throughput: one item per cycle; an end item waits only while the result
// register is full and not being taken.
// Reset (synchronous, active low) empties both registers, clears the fold
// state and sets the block width to 8 bits.
// ----------------------------------------------------------------------------
// xor_block_fold_core
// Longitudinal XOR checksum over a byte stream, folded in blocks of 4 to 64
// bits selected by the block width register.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_block_fold_core #(
    parameter int FOLD_WIDTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [xbf_pkg::LG_W-1:0]  i_cfg_wdata,
    xbf_in_if.sink                         i_in,
    xbf_out_if.source                      o_out
);

    // widest power-of-two block that fits the fold width
    localparam logic [xbf_pkg::LG_W-1:0] LG_CAP =
        (FOLD_WIDTH >= 64) ? xbf_pkg::LG_MAX :
        (FOLD_WIDTH >= 32) ? 3'd5 :
        (FOLD_WIDTH >= 16) ? 3'd4 : xbf_pkg::LG_BYTE;

    logic [xbf_pkg::LG_W-1:0] r_lg;
    logic [xbf_pkg::LG_W-1:0] n_lg;
    xbf_pkg::t_stage          stage;
    logic                     take;

    // clamp the written width once, at write time
    always_comb begin
        n_lg = r_lg;
        if (i_cfg_we) begin
            if (i_cfg_wdata < xbf_pkg::LG_NIBBLE) begin
                n_lg = xbf_pkg::LG_NIBBLE;
            end else if (i_cfg_wdata > LG_CAP) begin
                n_lg = LG_CAP;
            end else begin
                n_lg = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg <= (xbf_pkg::LG_RESET > LG_CAP) ? LG_CAP : xbf_pkg::LG_RESET;
        end else begin
            r_lg <= n_lg;
        end
    end

    xbf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    xbf_fold #(
        .W (FOLD_WIDTH)
    ) u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_lg    (r_lg),
        .i_stage (stage),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
